>>> sv/page_replacement_engine_unit_assert.svh
// Assertion macros for the page replacement engine.
`ifndef PAGE_REPLACEMENT_ENGINE_UNIT_ASSERT_SVH
`define PAGE_REPLACEMENT_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pre_pkg.sv
// Shared types and constants for the page replacement engine.
`default_nettype none

package pre_pkg;

	localparam int PAGE_COUNT  = 8;
	localparam int FRAME_COUNT = 4;
	localparam int PAGE_W      = 3;
	localparam int FRAME_W     = 2;
	localparam int CNT_W       = 32;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LRU  = 2'd1;
	localparam logic [1:0] POL_SC   = 2'd2;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              is_write;
	} in_word_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic               evicted;
		logic [PAGE_W-1:0]  victim_page;
		logic               writeback;
		logic [CNT_W-1:0]   refs_so_far;
		logic [CNT_W-1:0]   faults_so_far;
		logic [CNT_W-1:0]   disk_accesses_so_far;
	} out_word_t;

	typedef struct packed {
		logic               load;
		logic               lookup;
		logic               scan;
		logic               update;
		logic [FRAME_W-1:0] scan_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic full;
	} ctrl_sts_t;

endpackage

`default_nettype wire

>>> sv/pre_ctrl.sv
// Sequencer for lookup, victim scan and update of one reference.
`default_nettype none

module pre_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire pre_pkg::ctrl_sts_t sts,
	output logic                    busy,
	output pre_pkg::ctrl_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_UPDATE = 2'd3;

	localparam logic [pre_pkg::FRAME_W-1:0] LAST_FRAME =
		pre_pkg::FRAME_W'(pre_pkg::FRAME_COUNT - 1);

	logic [1:0]                  state_q;
	logic [pre_pkg::FRAME_W-1:0] cnt_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.load     = start && (state_q == S_IDLE);
		cmd.lookup   = (state_q == S_LOOKUP);
		cmd.scan     = (state_q == S_SCAN);
		cmd.update   = (state_q == S_UPDATE);
		cmd.scan_idx = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					cnt_q <= '0;
					// scan only when every frame is taken and the page is absent
					if (sts.hit || !sts.full) state_q <= S_UPDATE;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cnt_q == LAST_FRAME) state_q <= S_UPDATE;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/pre_datapath.sv
// Page table, frame table, age ranks, victim scan and running totals.
`default_nettype none

module pre_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pre_pkg::ctrl_cmd_t cmd,
	input  wire pre_pkg::in_word_t  item,
	input  wire logic [1:0]         policy,
	output pre_pkg::ctrl_sts_t      sts,
	output pre_pkg::out_word_t      result,
	output logic                    done
);

	localparam int PC = pre_pkg::PAGE_COUNT;
	localparam int FC = pre_pkg::FRAME_COUNT;
	localparam int FW = pre_pkg::FRAME_W;
	localparam int PW = pre_pkg::PAGE_W;
	localparam int CW = pre_pkg::CNT_W;

	logic [PC-1:0] present_q;
	logic [FW-1:0] pfi_q   [PC];
	logic [PW-1:0] owner_q [FC];
	logic [FW-1:0] rank_q  [FC];
	logic [FC-1:0] dirty_q;
	logic [FC-1:0] refd_q;
	logic [FW:0]   used_q;

	logic [CW-1:0] refs_q;
	logic [CW-1:0] faults_q;
	logic [CW-1:0] disk_q;

	logic [PW-1:0] page_q;
	logic          wr_q;
	logic          hit_q;
	logic          full_q;
	logic [FW-1:0] frame_q;

	logic          sc_found_q;
	logic [FW-1:0] sc_best_q;
	logic [FW-1:0] sc_rank_q;
	logic [FW-1:0] fb_best_q;
	logic [FW-1:0] fb_rank_q;

	pre_pkg::out_word_t result_q;
	logic               done_q;

	logic          evict;
	logic [FW-1:0] f_upd;
	logic [FW-1:0] cur_rank;
	logic          aging;
	logic [FW:0]   old_rank;
	logic [PW-1:0] victim_page;
	logic          wb;
	logic [CW-1:0] refs_nx;
	logic [CW-1:0] faults_nx;
	logic [CW:0]   disk_sum;
	logic [CW-1:0] disk_nx;

	assign sts.hit  = present_q[page_q];
	assign sts.full = (used_q == (FW+1)'(FC));

	assign evict       = !hit_q && full_q;
	assign f_upd       = evict ? (((policy == pre_pkg::POL_SC) && sc_found_q) ?
	                     sc_best_q : fb_best_q) : frame_q;
	assign cur_rank    = rank_q[cmd.scan_idx];
	assign aging       = !hit_q || (policy == pre_pkg::POL_LRU);
	assign old_rank    = (hit_q || full_q) ? {1'b0, rank_q[f_upd]} : (FW+1)'(FC);
	assign victim_page = evict ? owner_q[f_upd] : '0;
	assign wb          = evict && dirty_q[f_upd];

	assign refs_nx   = (refs_q == '1) ? refs_q : refs_q + 1'b1;
	assign faults_nx = (!hit_q && (faults_q != '1)) ? faults_q + 1'b1 : faults_q;
	assign disk_sum  = {1'b0, disk_q} + (CW+1)'(!hit_q) + (CW+1)'(wb);
	assign disk_nx   = disk_sum[CW] ? '1 : disk_sum[CW-1:0];

	// control state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			used_q    <= '0;
			refs_q    <= '0;
			faults_q  <= '0;
			disk_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				refs_q   <= refs_nx;
				faults_q <= faults_nx;
				disk_q   <= disk_nx;
				if (!hit_q) begin
					if (evict) present_q[victim_page] <= 1'b0;
					else used_q <= used_q + 1'b1;
					present_q[page_q] <= 1'b1;
				end
			end
		end
	end

	// latch the word, look it up, then scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= item.page;
			wr_q   <= item.is_write;
		end
		if (cmd.lookup) begin
			hit_q      <= sts.hit;
			full_q     <= sts.full;
			frame_q    <= sts.hit ? pfi_q[page_q] : used_q[FW-1:0];
			sc_found_q <= 1'b0;
		end
		if (cmd.scan) begin
			if ((policy == pre_pkg::POL_SC) && !refd_q[cmd.scan_idx] &&
			    (!sc_found_q || (cur_rank > sc_rank_q))) begin
				sc_found_q <= 1'b1;
				sc_best_q  <= cmd.scan_idx;
				sc_rank_q  <= cur_rank;
			end
			if ((cmd.scan_idx == '0) || (cur_rank > fb_rank_q)) begin
				fb_best_q <= cmd.scan_idx;
				fb_rank_q <= cur_rank;
			end
		end
	end

	// frame table and age ranks
	always_ff @(posedge clk) begin
		if (cmd.scan && (policy == pre_pkg::POL_SC)) refd_q[cmd.scan_idx] <= 1'b0;
		if (cmd.update) begin
			refd_q[f_upd] <= 1'b1;
			if (hit_q) begin
				dirty_q[f_upd] <= dirty_q[f_upd] | wr_q;
			end else begin
				dirty_q[f_upd] <= wr_q;
				owner_q[f_upd] <= page_q;
				pfi_q[page_q]  <= f_upd;
			end
			if (aging) begin
				for (int g = 0; g < FC; g++) begin
					if (((FW+1)'(g) < used_q) && (FW'(g) != f_upd) &&
					    ({1'b0, rank_q[g]} < old_rank))
						rank_q[g] <= rank_q[g] + 1'b1;
				end
				rank_q[f_upd] <= '0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.hit                  <= hit_q;
			result_q.frame                <= f_upd;
			result_q.evicted              <= evict;
			result_q.victim_page          <= victim_page;
			result_q.writeback            <= wb;
			result_q.refs_so_far          <= refs_nx;
			result_q.faults_so_far        <= faults_nx;
			result_q.disk_accesses_so_far <= disk_nx;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

>>> sv/page_replacement_engine_unit.sv
// Top level of the page replacement engine: register port, sequencer and datapath.
//
// Takes one page reference (page, is_write) when start is high and busy is low,
// and answers with one result word, marked by a single-cycle done strobe that
// the receiver cannot hold off. A hit, or a fault that fills a free frame, passes
// through the lookup and update states; a fault that evicts also passes through
// the victim scan, which visits one frame per cycle. busy drops in the cycle
// done is high, so the next reference can be taken in that cycle. The policy
// register (0 FIFO, 1 LRU, 2 second chance, 3 as FIFO) sits at byte address 0 and
// must be written by the user only while busy is low; the block does not check.
`default_nettype none

module page_replacement_engine_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire pre_pkg::in_word_t  item,
	output logic                    done,
	output pre_pkg::out_word_t      result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [1:0]         policy_q;
	pre_pkg::ctrl_cmd_t cmd;
	pre_pkg::ctrl_sts_t sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {30'd0, policy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pre_pkg::POL_FIFO;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			policy_q <= pwdata[1:0];
		end
	end

	pre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	pre_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.policy (policy_q),
		.sts    (sts),
		.result (result),
		.done   (done)
	);

`include "page_replacement_engine_unit_assert.svh"

	`PRE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`PRE_ASSERT_SAME(a_done_idle, done, !busy, "result word while still busy")
	`PRE_ASSERT_SAME(a_hit_no_evict, done && result.hit, !result.evicted, "hit with eviction")
	`PRE_ASSERT_SAME(a_wb_evict, done && result.writeback, result.evicted,
		"writeback without eviction")

endmodule

`default_nettype wire
